/* src/acbe_pkg.sv */
`default_nettype none
package acbe_pkg;

   localparam int ROUNDS_DEF  = 10;
   localparam int BLOCK_BYTES = 16;
   localparam int BLOCK_W     = BLOCK_BYTES * 8;
   localparam int HALF_W      = BLOCK_W / 2;
   localparam int CSR_IDX_W   = 3;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEY_HIGH = 3'd0,
      CSR_KEY_LOW  = 3'd1,
      CSR_IV_HIGH  = 3'd2,
      CSR_IV_LOW   = 3'd3,
      CSR_DECRYPT  = 3'd4
   } csr_index_type;

   // control from the top level to the cipher core
   typedef struct packed {
      logic start;
      logic decrypt;
      logic take;
   } ctl_type;

   // status from the cipher core
   typedef struct packed {
      logic idle;
      logic done;
   } stat_type;

   localparam logic [7:0] FWD_SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

   localparam logic [7:0] INV_SBOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

   // multiply by x in the field
   function automatic logic [7:0] xtime(input logic [7:0] v);
      xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   // multiply by a small constant, one bit per step
   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] k);
      logic [7:0] r;
      logic [7:0] x;
      r = '0;
      x = a;
      for (int i = 0; i < 4; i++) begin
         if (k[i]) r = r ^ x;
         x = xtime(x);
      end
      gmul = r;
   endfunction

   function automatic logic [7:0] get_byte(input logic [BLOCK_W-1:0] s, input int i);
      get_byte = s[BLOCK_W-1-8*i -: 8];
   endfunction

   // sub bytes then shift rows
   function automatic logic [BLOCK_W-1:0] sub_shift_fwd(input logic [BLOCK_W-1:0] s);
      logic [BLOCK_W-1:0] o;
      o = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            o[BLOCK_W-1-8*(c*4+r) -: 8] = FWD_SBOX[get_byte(s, ((c+r)%4)*4+r)];
         end
      end
      sub_shift_fwd = o;
   endfunction

   // inverse shift rows then inverse sub bytes
   function automatic logic [BLOCK_W-1:0] sub_shift_inv(input logic [BLOCK_W-1:0] s);
      logic [BLOCK_W-1:0] o;
      o = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            o[BLOCK_W-1-8*(((c+r)%4)*4+r) -: 8] = INV_SBOX[get_byte(s, c*4+r)];
         end
      end
      sub_shift_inv = o;
   endfunction

   // mix columns, forward or inverse coefficients
   function automatic logic [BLOCK_W-1:0] mix_cols(input logic [BLOCK_W-1:0] s,
                                                   input logic inv);
      logic [BLOCK_W-1:0] o;
      logic [7:0] a0, a1, a2, a3;
      logic [3:0] m0, m1, m2, m3;
      o  = '0;
      m0 = inv ? 4'd14 : 4'd2;
      m1 = inv ? 4'd11 : 4'd3;
      m2 = inv ? 4'd13 : 4'd1;
      m3 = inv ? 4'd9  : 4'd1;
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(s, c*4);
         a1 = get_byte(s, c*4+1);
         a2 = get_byte(s, c*4+2);
         a3 = get_byte(s, c*4+3);
         o[BLOCK_W-1-8*(c*4)   -: 8] = gmul(a0,m0) ^ gmul(a1,m1) ^ gmul(a2,m2) ^ gmul(a3,m3);
         o[BLOCK_W-1-8*(c*4+1) -: 8] = gmul(a0,m3) ^ gmul(a1,m0) ^ gmul(a2,m1) ^ gmul(a3,m2);
         o[BLOCK_W-1-8*(c*4+2) -: 8] = gmul(a0,m2) ^ gmul(a1,m3) ^ gmul(a2,m0) ^ gmul(a3,m1);
         o[BLOCK_W-1-8*(c*4+3) -: 8] = gmul(a0,m1) ^ gmul(a1,m2) ^ gmul(a2,m3) ^ gmul(a3,m0);
      end
      mix_cols = o;
   endfunction

   // next round key from the previous one
   function automatic logic [BLOCK_W-1:0] key_step(input logic [BLOCK_W-1:0] k,
                                                   input logic [7:0] rc);
      logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3;
      w0 = k[127:96];
      w1 = k[95:64];
      w2 = k[63:32];
      w3 = k[31:0];
      t  = {FWD_SBOX[w3[23:16]] ^ rc, FWD_SBOX[w3[15:8]], FWD_SBOX[w3[7:0]],
            FWD_SBOX[w3[31:24]]};
      n0 = w0 ^ t;
      n1 = w1 ^ n0;
      n2 = w2 ^ n1;
      n3 = w3 ^ n2;
      key_step = {n0, n1, n2, n3};
   endfunction

endpackage
`default_nettype wire

/* src/acbe_if.sv */
`default_nettype none
interface acbe_req_if;
   logic                     valid;
   logic                     ready;
   logic [acbe_pkg::HALF_W-1:0] block_high;
   logic [acbe_pkg::HALF_W-1:0] block_low;
   logic                     restart;
   modport source (output valid, block_high, block_low, restart, input ready);
   modport sink (input valid, block_high, block_low, restart, output ready);
endinterface

interface acbe_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [acbe_pkg::HALF_W-1:0] out_high;
   logic [acbe_pkg::HALF_W-1:0] out_low;
   modport source (output valid, out_high, out_low, input ready);
   modport sink (input valid, out_high, out_low, output ready);
endinterface
`default_nettype wire

/* src/acbe_keymem.sv */
`default_nettype none
module acbe_keymem #(
   parameter int ROUNDS = acbe_pkg::ROUNDS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [acbe_pkg::BLOCK_W-1:0]     key,
   input  wire logic [$clog2(ROUNDS+1)-1:0]      rd_addr,
   output logic      [acbe_pkg::BLOCK_W-1:0]     rd_data,
   output logic                                  busy
);
   localparam int KW    = $clog2(ROUNDS+1);
   localparam int DEPTH = ROUNDS + 1;

   logic [acbe_pkg::BLOCK_W-1:0] mem [DEPTH];
   logic [acbe_pkg::BLOCK_W-1:0] rd_ff;
   logic [acbe_pkg::BLOCK_W-1:0] cur_ff, cur_in;
   logic [7:0]                   rc_ff, rc_in;
   logic [KW-1:0]                idx_ff, idx_in;
   logic                         act_ff, act_in;

   // expansion sequencer, one round key per cycle
   always_comb begin
      cur_in = (idx_ff == '0) ? key : acbe_pkg::key_step(cur_ff, rc_ff);
      rc_in  = (idx_ff == '0) ? 8'h01 : acbe_pkg::xtime(rc_ff);
      idx_in = idx_ff;
      act_in = act_ff;
      if (start) begin
         idx_in = '0;
         act_in = 1'b1;
      end else if (act_ff) begin
         idx_in = KW'(idx_ff + 1'b1);
         if (idx_ff == KW'(ROUNDS)) act_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b1;
         idx_ff <= '0;
      end else begin
         act_ff <= act_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (act_ff && !start) begin
         cur_ff <= cur_in;
         rc_ff  <= rc_in;
      end
   end

   // round key store, registered read
   always_ff @(posedge clock) begin
      if (act_ff && !start) mem[idx_ff] <= cur_in;
      rd_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ff;
   assign busy    = act_ff;
endmodule
`default_nettype wire

/* src/acbe_cipher.sv */
`default_nettype none
module acbe_cipher #(
   parameter int ROUNDS = acbe_pkg::ROUNDS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire acbe_pkg::ctl_type                ctl,
   input  wire logic [acbe_pkg::BLOCK_W-1:0]     din,
   input  wire logic [acbe_pkg::BLOCK_W-1:0]     key_data,
   output logic      [$clog2(ROUNDS+1)-1:0]      key_addr,
   output acbe_pkg::stat_type                    stat,
   output logic      [acbe_pkg::BLOCK_W-1:0]     dout
);
   localparam int KW = $clog2(ROUNDS+1);

   typedef enum logic [3:0] {
      CS_IDLE  = 4'b0001,
      CS_LOAD  = 4'b0010,
      CS_ROUND = 4'b0100,
      CS_DONE  = 4'b1000
   } cstate_type;

   cstate_type                   state_ff, state_in;
   logic [KW-1:0]                rnd_ff, rnd_in;
   logic                         dec_ff;
   logic [acbe_pkg::BLOCK_W-1:0] st_ff, st_in;
   logic [acbe_pkg::BLOCK_W-1:0] ss_f, ss_i, t_dec, enc_nx, dec_nx;
   logic [KW-1:0]                step;
   logic                         last;

   // key address runs one step ahead of the round unit
   always_comb begin
      step     = (state_ff == CS_LOAD) ? '0 : KW'(rnd_ff + 1'b1);
      key_addr = dec_ff ? KW'(KW'(ROUNDS) - step) : step;
   end

   // one round per cycle
   always_comb begin
      last   = (rnd_ff == KW'(ROUNDS));
      ss_f   = acbe_pkg::sub_shift_fwd(st_ff);
      ss_i   = acbe_pkg::sub_shift_inv(st_ff);
      enc_nx = (last ? ss_f : acbe_pkg::mix_cols(ss_f, 1'b0)) ^ key_data;
      t_dec  = ss_i ^ key_data;
      dec_nx = last ? t_dec : acbe_pkg::mix_cols(t_dec, 1'b1);
   end

   always_comb begin
      state_in = state_ff;
      rnd_in   = rnd_ff;
      st_in    = st_ff;
      case (state_ff)
         CS_IDLE: begin
            if (ctl.start) begin
               state_in = CS_LOAD;
               st_in    = din;
            end
         end
         CS_LOAD: begin
            state_in = CS_ROUND;
            rnd_in   = '0;
         end
         CS_ROUND: begin
            if (rnd_ff == '0) st_in = st_ff ^ key_data;
            else st_in = dec_ff ? dec_nx : enc_nx;
            if (last) state_in = CS_DONE;
            else rnd_in = KW'(rnd_ff + 1'b1);
         end
         CS_DONE: begin
            if (ctl.take) state_in = CS_IDLE;
         end
         default: state_in = CS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= CS_IDLE;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      rnd_ff <= rnd_in;
      st_ff  <= st_in;
      if (state_ff == CS_IDLE && ctl.start) dec_ff <= ctl.decrypt;
   end

   assign stat.idle = (state_ff == CS_IDLE);
   assign stat.done = (state_ff == CS_DONE);
   assign dout      = st_ff;
endmodule
`default_nettype wire

/* src/aes128_cbc_block_engine_top.sv */
// item path: a load state for the first key read, the round states on the shared
//   round unit, then a done state that hands off once the output register is free
// items: a new item is accepted only once the cipher is back in idle; the round
//   loop and the key store read port serve one block at a time
// reset: round keys are expanded from the all-zero key, with no item accepted
//   meanwhile; each key register write re-runs that expansion; chain is zero
`default_nettype none
module aes128_cbc_block_engine_top #(
   parameter int ROUNDS = acbe_pkg::ROUNDS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   acbe_req_if.sink                               req_if,
   acbe_rsp_if.source                             rsp_if,
   input  wire logic                              csr_we,
   input  wire logic [acbe_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [acbe_pkg::HALF_W-1:0]       csr_wdata
);
   localparam int KW = $clog2(ROUNDS+1);

   logic [acbe_pkg::HALF_W-1:0]  key_hi_ff, key_lo_ff, iv_hi_ff, iv_lo_ff;
   logic                         dec_ff;
   logic [acbe_pkg::BLOCK_W-1:0] chain_ff, blk_ff, out_ff;
   logic                         out_vld_ff;
   logic                         key_start, key_busy, accept;
   logic [KW-1:0]                key_addr;
   logic [acbe_pkg::BLOCK_W-1:0] key_data, cdin, cdout, blk;
   acbe_pkg::ctl_type            ctl;
   acbe_pkg::stat_type           stat;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff <= '0;
         key_lo_ff <= '0;
         iv_hi_ff  <= '0;
         iv_lo_ff  <= '0;
         dec_ff    <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            acbe_pkg::CSR_KEY_HIGH: key_hi_ff <= csr_wdata;
            acbe_pkg::CSR_KEY_LOW:  key_lo_ff <= csr_wdata;
            acbe_pkg::CSR_IV_HIGH:  iv_hi_ff  <= csr_wdata;
            acbe_pkg::CSR_IV_LOW:   iv_lo_ff  <= csr_wdata;
            acbe_pkg::CSR_DECRYPT:  dec_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign key_start = csr_we && (csr_index == acbe_pkg::CSR_KEY_HIGH ||
                                 csr_index == acbe_pkg::CSR_KEY_LOW);

   // input handshake and cipher control
   assign req_if.ready = stat.idle && !key_busy;
   assign accept       = req_if.valid && req_if.ready;
   assign blk          = {req_if.block_high, req_if.block_low};
   assign cdin         = dec_ff ? blk
                                : blk ^ (req_if.restart ? {iv_hi_ff, iv_lo_ff} : chain_ff);
   assign ctl.start    = accept;
   assign ctl.decrypt  = dec_ff;
   assign ctl.take     = stat.done && (!out_vld_ff || rsp_if.ready);

   acbe_keymem #(.ROUNDS(ROUNDS)) u_keymem (
      .clock   (clock),
      .reset   (reset),
      .start   (key_start),
      .key     ({key_hi_ff, key_lo_ff}),
      .rd_addr (key_addr),
      .rd_data (key_data),
      .busy    (key_busy)
   );

   acbe_cipher #(.ROUNDS(ROUNDS)) u_cipher (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .din      (cdin),
      .key_data (key_data),
      .key_addr (key_addr),
      .stat     (stat),
      .dout     (cdout)
   );

   // chain value and held block
   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= '0;
      end else if (accept) begin
         if (req_if.restart) chain_ff <= {iv_hi_ff, iv_lo_ff};
      end else if (ctl.take) begin
         chain_ff <= dec_ff ? blk_ff : cdout;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) blk_ff <= blk;
      if (ctl.take) out_ff <= dec_ff ? cdout ^ chain_ff : cdout;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else if (ctl.take) out_vld_ff <= 1'b1;
      else if (rsp_if.ready) out_vld_ff <= 1'b0;
   end

   assign rsp_if.valid    = out_vld_ff;
   assign rsp_if.out_high = out_ff[acbe_pkg::BLOCK_W-1:acbe_pkg::HALF_W];
   assign rsp_if.out_low  = out_ff[acbe_pkg::HALF_W-1:0];

   // checks
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> !stat.idle) else $error("cipher did not start on accepted item");
   a_key_busy: assert property (@(posedge clock) disable iff (reset)
      key_start |=> key_busy) else $error("key expansion did not start");
   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      (stat.done && !ctl.take) |=> stat.done) else $error("finished block lost");
   a_no_accept_exp: assert property (@(posedge clock) disable iff (reset)
      key_busy |-> !accept) else $error("item accepted during key expansion");
endmodule
`default_nettype wire
